// File: rtl/lstc_pkg.sv
// Shared constants, types and the line code table for the line sensor track classifier.
`timescale 1ns / 1ps
`default_nettype none

package lstc_pkg;

   // Geometry
   localparam int WINDOW_DEPTH = 49;
   localparam int CHANNELS     = 5;
   localparam int SAMPLE_W     = 12;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int WIN_DATA_W   = CHANNELS * SAMPLE_W;
   localparam int SUM_W        = SAMPLE_W + WIN_AW;

   // Floor division by the window depth as multiply and shift; exact for any sum below 2**SUM_W
   localparam int RECIP_SHIFT = SUM_W + WIN_AW;
   localparam int RECIP_W     = SUM_W + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(WINDOW_DEPTH) - 1)
               / longint'(WINDOW_DEPTH));

   // Threshold widths: white - bias, and white - offset + bias
   localparam int THR_W_W = SAMPLE_W + 1;
   localparam int THR_R_W = SAMPLE_W + 2;

   // Result queue (depth is a power of two)
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = SAMPLE_W;

   // Reset values
   localparam logic [SAMPLE_W-1:0] WHITE_RESET  = SAMPLE_W'(2000);
   localparam logic [SAMPLE_W-1:0] OFFSET_RESET = SAMPLE_W'(400);
   localparam logic [SAMPLE_W-1:0] BIAS_RESET   = SAMPLE_W'(100);
   localparam logic [SAMPLE_W-1:0] BLACK_RESET  = SAMPLE_W'(500);

   typedef enum logic {
      CMD_CALIBRATE = 1'b0,
      CMD_TRACK     = 1'b1
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WHITE_TO_RED_OFFSET = 2'd0,
      CSR_BIAS_MARGIN         = 2'd1,
      CSR_BLACK_MAX_LEVEL     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      LEVEL_WHITE   = 2'd0,
      LEVEL_RED     = 2'd1,
      LEVEL_BLACK   = 2'd2,
      LEVEL_BETWEEN = 2'd3
   } level_type;

   typedef enum logic [3:0] {
      CODE_WHITE     = 4'd0,
      CODE_MIDDLE    = 4'd1,
      CODE_LEFT      = 4'd2,
      CODE_RIGHT     = 4'd3,
      CODE_FAR_LEFT  = 4'd4,
      CODE_FAR_RIGHT = 4'd5,
      CODE_RED       = 4'd6,
      CODE_TEE       = 4'd7,
      CODE_BLACK     = 4'd8,
      CODE_ERROR     = 4'd9,
      CODE_NONE      = 4'd10
   } line_code_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] offset;
      logic [SAMPLE_W-1:0] bias;
      logic [SAMPLE_W-1:0] black;
   } cfg_type;

   typedef struct packed {
      line_code_type               line_code;
      level_type [CHANNELS-1:0]    level;
   } result_type;

   typedef struct packed {
      logic       push;
      logic [1:0] inflight;
   } front_status_type;

   typedef struct packed {
      logic [QUEUE_AW:0] count;
      logic              full;
      logic              empty;
   } queue_status_type;

   // Level pattern, leftmost sensor first, two bits a digit
   function automatic line_code_type line_code_of(input level_type [CHANNELS-1:0] lv);
      logic [2*CHANNELS-1:0] key;
      line_code_type         code;
      key = {lv[0], lv[1], lv[2], lv[3], lv[4]};
      unique case (key)
         10'b00_00_00_00_00:                     code = CODE_WHITE;
         10'b00_00_01_00_00, 10'b00_01_01_01_00: code = CODE_MIDDLE;
         10'b00_01_00_00_00, 10'b00_01_01_00_00: code = CODE_LEFT;
         10'b00_00_00_01_00, 10'b00_00_01_01_00: code = CODE_RIGHT;
         10'b01_00_00_00_00, 10'b01_01_00_00_00: code = CODE_FAR_LEFT;
         10'b00_00_00_00_01, 10'b00_00_00_01_01: code = CODE_FAR_RIGHT;
         10'b01_01_01_01_01, 10'b01_01_01_01_00,
         10'b00_01_01_01_01, 10'b01_00_01_01_01,
         10'b01_01_01_00_01:                     code = CODE_RED;
         10'b01_01_00_01_01:                     code = CODE_TEE;
         10'b10_10_00_10_10, 10'b10_10_10_10_10,
         10'b00_10_10_10_10, 10'b10_10_10_10_00: code = CODE_BLACK;
         10'b01_01_01_00_00:                     code = CODE_NONE;
         default:                                code = CODE_ERROR;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// File: rtl/lstc_if.sv
// Valid/ready channel interfaces for sample words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface lstc_req_if import lstc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                command;
   logic [SAMPLE_W-1:0] sample_0;
   logic [SAMPLE_W-1:0] sample_1;
   logic [SAMPLE_W-1:0] sample_2;
   logic [SAMPLE_W-1:0] sample_3;
   logic [SAMPLE_W-1:0] sample_4;

   modport source (
      output valid, command, sample_0, sample_1, sample_2, sample_3, sample_4,
      input  ready
   );
   modport sink (
      input  valid, command, sample_0, sample_1, sample_2, sample_3, sample_4,
      output ready
   );
endinterface

interface lstc_rsp_if import lstc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [3:0] line_code;
   logic [1:0] level_0;
   logic [1:0] level_1;
   logic [1:0] level_2;
   logic [1:0] level_3;
   logic [1:0] level_4;

   modport source (
      output valid, line_code, level_0, level_1, level_2, level_3, level_4,
      input  ready
   );
   modport sink (
      input  valid, line_code, level_0, level_1, level_2, level_3, level_4,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/lstc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lstc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/lstc_front.sv
// Front part: window position tracking, moving average, thresholds and classification.
`timescale 1ns / 1ps
`default_nettype none

module lstc_front import lstc_pkg::*; (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_accept,
   input  wire logic                                in_command,
   input  wire logic [CHANNELS-1:0][SAMPLE_W-1:0]   in_samples,
   input  wire cfg_type                             cfg,
   output result_type                               res,
   output front_status_type                         status
);

   // Accept-side window bookkeeping
   logic [WIN_AW-1:0] pos_ff, pos_in;
   logic              primed_ff, primed_in;
   logic              filled_ff, filled_in;
   logic              is_track;

   // Stage 1: accepted word, window read data arrives alongside
   logic                              s1_valid_ff;
   logic                              s1_track_ff;
   logic                              s1_prime_ff;
   logic                              s1_use_prime_ff;
   logic [WIN_AW-1:0]                 s1_addr_ff;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] s1_sample_ff;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] win_rd;
   logic                              win_wr_en;

   // Per-channel running state
   logic [SAMPLE_W-1:0] white_ff [CHANNELS];
   logic [SAMPLE_W-1:0] white_in [CHANNELS];
   logic [SUM_W-1:0]    sum_ff   [CHANNELS];
   logic [SUM_W-1:0]    sum_in   [CHANNELS];
   logic [SAMPLE_W-1:0] prime_ff [CHANNELS];

   logic signed [THR_W_W-1:0] thr_w_in [CHANNELS];
   logic signed [THR_R_W-1:0] thr_r_in [CHANNELS];
   logic                      raw_hi_in [CHANNELS];

   // Stage 2: new sums and thresholds
   logic                      s2_valid_ff;
   logic [SUM_W-1:0]          s2_sum_ff    [CHANNELS];
   logic signed [THR_W_W-1:0] s2_thr_w_ff  [CHANNELS];
   logic signed [THR_R_W-1:0] s2_thr_r_ff  [CHANNELS];
   logic                      s2_raw_hi_ff [CHANNELS];

   // Stage 3: reciprocal products
   logic                      s3_valid_ff;
   logic [PROD_W-1:0]         s3_prod_ff   [CHANNELS];
   logic signed [THR_W_W-1:0] s3_thr_w_ff  [CHANNELS];
   logic signed [THR_R_W-1:0] s3_thr_r_ff  [CHANNELS];
   logic                      s3_raw_hi_ff [CHANNELS];

   level_type [CHANNELS-1:0] levels;

   assign is_track = (in_command == CMD_TRACK);

   // Position advances at accept so back-to-back words read the right entry
   always_comb begin
      pos_in    = pos_ff;
      primed_in = primed_ff;
      filled_in = filled_ff;
      if (in_accept && is_track) begin
         if (!primed_ff) begin
            primed_in = 1'b1;
         end else if (pos_ff == WIN_AW'(WINDOW_DEPTH - 1)) begin
            pos_in    = '0;
            filled_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         primed_ff   <= 1'b0;
         filled_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         primed_ff   <= primed_in;
         filled_ff   <= filled_in;
         s1_valid_ff <= in_accept;
         s2_valid_ff <= s1_valid_ff && s1_track_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_track_ff     <= is_track;
      s1_prime_ff     <= !primed_ff;
      s1_use_prime_ff <= !filled_ff;
      s1_addr_ff      <= pos_ff;
      s1_sample_ff    <= in_samples;
   end

   // Window storage, all channels side by side in one word
   assign win_wr_en = s1_valid_ff && s1_track_ff && !s1_prime_ff;

   lstc_ram #(
      .WIDTH (WIN_DATA_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sample_ff),
      .rd_addr (pos_ff),
      .rd_data (win_rd)
   );

   // Stage 1 math: sum update, calibration, thresholds
   always_comb begin
      logic [SAMPLE_W-1:0] old_entry;
      for (int c = 0; c < CHANNELS; c++) begin
         old_entry = s1_use_prime_ff ? prime_ff[c] : win_rd[c];
         sum_in[c]   = sum_ff[c];
         white_in[c] = white_ff[c];
         if (s1_valid_ff && s1_track_ff) begin
            if (s1_prime_ff) begin
               sum_in[c] = SUM_W'(s1_sample_ff[c]) * SUM_W'(WINDOW_DEPTH);
            end else begin
               sum_in[c] = sum_ff[c] - SUM_W'(old_entry) + SUM_W'(s1_sample_ff[c]);
            end
         end
         if (s1_valid_ff && !s1_track_ff && (s1_sample_ff[c] != '0)
             && (white_ff[c] > s1_sample_ff[c])) begin
            white_in[c] = s1_sample_ff[c];
         end
         thr_w_in[c] = signed'({1'b0, white_ff[c]}) - signed'({1'b0, cfg.bias});
         thr_r_in[c] = signed'({2'b00, white_ff[c]}) - signed'({2'b00, cfg.offset})
                       + signed'({2'b00, cfg.bias});
         raw_hi_in[c] = s1_sample_ff[c] > cfg.black;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (reset) begin
            white_ff[c] <= WHITE_RESET;
            sum_ff[c]   <= '0;
         end else begin
            white_ff[c] <= white_in[c];
            sum_ff[c]   <= sum_in[c];
         end
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (s1_valid_ff && s1_track_ff && s1_prime_ff) begin
            prime_ff[c] <= s1_sample_ff[c];
         end
         s2_sum_ff[c]    <= sum_in[c];
         s2_thr_w_ff[c]  <= thr_w_in[c];
         s2_thr_r_ff[c]  <= thr_r_in[c];
         s2_raw_hi_ff[c] <= raw_hi_in[c];
         s3_prod_ff[c]   <= PROD_W'(s2_sum_ff[c]) * PROD_W'(RECIP);
         s3_thr_w_ff[c]  <= s2_thr_w_ff[c];
         s3_thr_r_ff[c]  <= s2_thr_r_ff[c];
         s3_raw_hi_ff[c] <= s2_raw_hi_ff[c];
      end
   end

   // Stage 3: average and level per channel
   always_comb begin
      logic [SAMPLE_W-1:0]       avg;
      logic signed [THR_R_W-1:0] avg_s;
      for (int c = 0; c < CHANNELS; c++) begin
         avg   = s3_prod_ff[c][RECIP_SHIFT +: SAMPLE_W];
         avg_s = signed'({2'b00, avg});
         priority if (avg_s > THR_R_W'(s3_thr_w_ff[c])) begin
            levels[c] = LEVEL_WHITE;
         end else if ((avg_s <= s3_thr_r_ff[c]) && s3_raw_hi_ff[c]) begin
            levels[c] = LEVEL_RED;
         end else if (avg <= cfg.black) begin
            levels[c] = LEVEL_BLACK;
         end else begin
            levels[c] = LEVEL_BETWEEN;
         end
      end
   end

   assign res.level     = levels;
   assign res.line_code = line_code_of(levels);

   assign status.push     = s3_valid_ff;
   assign status.inflight = 2'(s1_valid_ff && s1_track_ff) + 2'(s2_valid_ff)
                            + 2'(s3_valid_ff);

endmodule

`default_nettype wire

// File: rtl/lstc_queue.sv
// Back part: result queue that holds finished words until the receiver takes them.
`timescale 1ns / 1ps
`default_nettype none

module lstc_queue import lstc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   input  wire logic       pop,
   output result_type      head,
   output queue_status_type status
);

   result_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff,  count_in;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// File: rtl/line_sensor_track_classifier_unit.sv
// Top level of the line sensor track classifier: register port, front part, result queue.
//
// Usage:
//  req_chan carries one word per set of five 12-bit sensor samples plus a command bit.
//  Command calibrate lowers each channel's white minimum (zero samples skipped) and
//  returns nothing; command track runs each channel through its moving average,
//  classifies it into white, red, black or between, and returns one word on rsp_chan
//  with the five levels and the line code.
//  Throughput: one word per cycle, sustained, while rsp_chan drains.
//  Path: a track word goes through window RAM read, sum update, reciprocal multiply,
//  classify and the queue before it can be taken on rsp_chan.
//  Stalls: results collect in an 8-entry queue; req_chan.ready drops once the words
//  in the pipeline plus the queued words would fill it, so nothing is lost.
//  Reset (synchronous): registers go to 400/100/500, white minimums to 2000, sums and
//  window position to zero, the window unprimed and the queue empty. The window RAM
//  is not cleared: the first track word primes every entry through a fill flag.
//  csr_wr_en/csr_index/csr_wr_data write a register; write only while the block is idle
//  (the block itself does not enforce this); an index past the last register is ignored.
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_track_classifier_unit import lstc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   lstc_req_if.sink                    req_chan,
   lstc_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type                           cfg_ff, cfg_in;
   logic                              in_accept;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] in_samples;
   result_type                        front_res;
   front_status_type                  front_status;
   result_type                        q_head;
   queue_status_type                  q_status;
   logic [QUEUE_AW+1:0]               credit_used;
   logic                              rsp_pop;

   // Register port
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WHITE_TO_RED_OFFSET: cfg_in.offset = csr_wr_data;
            CSR_BIAS_MARGIN:         cfg_in.bias   = csr_wr_data;
            CSR_BLACK_MAX_LEVEL:     cfg_in.black  = csr_wr_data;
            default:                 cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset <= OFFSET_RESET;
         cfg_ff.bias   <= BIAS_RESET;
         cfg_ff.black  <= BLACK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Credit: accept only while every word in flight has a queue slot
   assign credit_used = (QUEUE_AW + 2)'(q_status.count) + (QUEUE_AW + 2)'(front_status.inflight);
   assign req_chan.ready = credit_used < (QUEUE_AW + 2)'(QUEUE_DEPTH);
   assign in_accept      = req_chan.valid && req_chan.ready;

   assign in_samples[0] = req_chan.sample_0;
   assign in_samples[1] = req_chan.sample_1;
   assign in_samples[2] = req_chan.sample_2;
   assign in_samples[3] = req_chan.sample_3;
   assign in_samples[4] = req_chan.sample_4;

   lstc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (in_accept),
      .in_command (req_chan.command),
      .in_samples (in_samples),
      .cfg        (cfg_ff),
      .res        (front_res),
      .status     (front_status)
   );

   assign rsp_pop = rsp_chan.valid && rsp_chan.ready;

   lstc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_status.push),
      .push_data (front_res),
      .pop       (rsp_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // Result channel
   assign rsp_chan.valid     = !q_status.empty;
   assign rsp_chan.line_code = q_head.line_code;
   assign rsp_chan.level_0   = q_head.level[0];
   assign rsp_chan.level_1   = q_head.level[1];
   assign rsp_chan.level_2   = q_head.level[2];
   assign rsp_chan.level_3   = q_head.level[3];
   assign rsp_chan.level_4   = q_head.level[4];

   // Checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      front_status.push |-> !q_status.full)
      else $error("result pushed into a full queue");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_used <= (QUEUE_AW + 2)'(QUEUE_DEPTH))
      else $error("words in flight exceed queue space");

   a_track_result: assert property (@(posedge clock) disable iff (reset)
      (in_accept && (req_chan.command == CMD_TRACK)) |-> ##3 front_status.push)
      else $error("track word produced no result");

   a_calibrate_silent: assert property (@(posedge clock) disable iff (reset)
      (in_accept && (req_chan.command == CMD_CALIBRATE)) |-> ##3 !front_status.push)
      else $error("calibrate word produced a result");

endmodule

`default_nettype wire

// File: tb/line_sensor_track_classifier_unit_test.sv
// Self-checking testbench for the line sensor track classifier: moving average, levels and line codes.
`timescale 1ns / 1ps

module line_sensor_track_classifier_unit_test;
   import lstc_pkg::*;

   localparam int IDLE_PCT     = 12;
   localparam int DRAIN_CYCLES = 10;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
   localparam int N_TARGETS    = 23;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 2'd3;

   typedef struct packed {
      command_type                         cmd;
      logic [CHANNELS-1:0][SAMPLE_W-1:0]   smp;
   } sensor_word_type;

   logic clock;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   lstc_req_if req_chan ();
   lstc_rsp_if rsp_chan ();

   line_sensor_track_classifier_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the block state
   logic [SAMPLE_W-1:0] offset_reg, bias_reg, black_reg;
   logic [SAMPLE_W-1:0] white_low  [CHANNELS];
   logic [SAMPLE_W-1:0] avg_window [CHANNELS][WINDOW_DEPTH];
   logic [SUM_W-1:0]    run_sum    [CHANNELS];
   int                  win_pos;
   bit                  primed;

   result_type expected_results [$];

   // Level patterns (level_0 first, one decimal digit per sensor) the random traffic aims at
   int target_patterns [N_TARGETS] = '{0, 100, 1110, 1000, 1100, 10, 110, 10000, 11000, 1, 11,
                                       11111, 11110, 1111, 10111, 11101, 11011, 22022, 22222,
                                       2222, 22220, 11100, 111};

   int  error_count     = 0;
   int  track_words     = 0;
   int  calibrate_words = 0;
   int  results_checked = 0;
   int  n_settings      = 0;
   bit  steady_flow     = 1'b0;
   bit  code_seen [16];

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic level_type classify(input int avg, input int raw, input int white);
      int off, bias, blk;
      off  = int'(offset_reg);
      bias = int'(bias_reg);
      blk  = int'(black_reg);
      if (avg > white - bias) return LEVEL_WHITE;
      if (avg <= white - off + bias && raw > blk) return LEVEL_RED;
      if (avg <= blk) return LEVEL_BLACK;
      return LEVEL_BETWEEN;
   endfunction

   // Read the five levels as a decimal number, leftmost sensor most significant
   function automatic line_code_type line_code_for(input level_type [CHANNELS-1:0] lv);
      int pat, c;
      pat = 0;
      for (c = 0; c < CHANNELS; c++) pat = pat * 10 + int'(lv[c]);
      case (pat)
         0:                                return CODE_WHITE;
         100, 1110:                        return CODE_MIDDLE;
         1000, 1100:                       return CODE_LEFT;
         10, 110:                          return CODE_RIGHT;
         10000, 11000:                     return CODE_FAR_LEFT;
         1, 11:                            return CODE_FAR_RIGHT;
         11111, 11110, 1111, 10111, 11101: return CODE_RED;
         11011:                            return CODE_TEE;
         22022, 22222, 2222, 22220:        return CODE_BLACK;
         11100:                            return CODE_NONE;
         default:                          return CODE_ERROR;
      endcase
   endfunction

   function automatic result_type track_step(input sensor_word_type w);
      result_type r;
      int c, k;
      for (c = 0; c < CHANNELS; c++) begin
         if (!primed) begin
            // first track word fills the whole window
            for (k = 0; k < WINDOW_DEPTH; k++) avg_window[c][k] = w.smp[c];
            run_sum[c] = SUM_W'(w.smp[c] * WINDOW_DEPTH);
         end else begin
            run_sum[c] = run_sum[c] - avg_window[c][win_pos] + w.smp[c];
            avg_window[c][win_pos] = w.smp[c];
         end
         r.level[c] = classify(int'(run_sum[c] / WINDOW_DEPTH), int'(w.smp[c]),
                               int'(white_low[c]));
      end
      if (primed) win_pos = (win_pos == WINDOW_DEPTH - 1) ? 0 : win_pos + 1;
      primed      = 1'b1;
      r.line_code = line_code_for(r.level);
      return r;
   endfunction

   function automatic void calibrate_step(input sensor_word_type w);
      int c;
      for (c = 0; c < CHANNELS; c++)
         if (w.smp[c] != '0 && w.smp[c] < white_low[c]) white_low[c] = w.smp[c];
   endfunction

   // Steady-state sample that lands in the wanted level, random when none can
   function automatic logic [SAMPLE_W-1:0] sample_for_level(input int ch, input level_type lv);
      int w, off, bias, blk, lo, hi;
      w    = int'(white_low[ch]);
      off  = int'(offset_reg);
      bias = int'(bias_reg);
      blk  = int'(black_reg);
      case (lv)
         LEVEL_WHITE: begin
            lo = w - bias + 1;
            hi = SAMPLE_MAX;
         end
         LEVEL_RED: begin
            lo = blk + 1;
            hi = w - off + bias;
            if (w - bias < hi) hi = w - bias;
         end
         LEVEL_BLACK: begin
            lo = 0;
            hi = blk;
            if (w - bias < hi) hi = w - bias;
         end
         default: begin
            lo = blk + 1;
            if (w - off + bias + 1 > lo) lo = w - off + bias + 1;
            hi = w - bias;
         end
      endcase
      if (lo < 0) lo = 0;
      if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
      if (lo > hi) return SAMPLE_W'($urandom_range(SAMPLE_MAX));
      return SAMPLE_W'($urandom_range(hi, lo));
   endfunction

   // ---------------------------------------------------------------- drivers

   // Send one word; the prediction is made at the accepting edge
   task automatic send_word(input sensor_word_type w);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.command  <= w.cmd;
      req_chan.sample_0 <= w.smp[0];
      req_chan.sample_1 <= w.smp[1];
      req_chan.sample_2 <= w.smp[2];
      req_chan.sample_3 <= w.smp[3];
      req_chan.sample_4 <= w.smp[4];
      do @(posedge clock); while (!req_chan.ready);
      if (w.cmd == CMD_TRACK) begin
         expected_results.push_back(track_step(w));
         track_words++;
      end else begin
         calibrate_step(w);
         calibrate_words++;
      end
   endtask

   // Drop valid, let every expected result come back, then let calibrate words settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_wr_en high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      case (idx)
         CSR_WHITE_TO_RED_OFFSET: offset_reg = val;
         CSR_BIAS_MARGIN:         bias_reg   = val;
         CSR_BLACK_MAX_LEVEL:     black_reg  = val;
         default: ;  // past the last register: dropped
      endcase
   endtask

   task automatic set_config(input logic [SAMPLE_W-1:0] offset, bias, black);
      wait_idle();
      write_csr(CSR_WHITE_TO_RED_OFFSET, offset);
      write_csr(CSR_BIAS_MARGIN, bias);
      write_csr(CSR_BLACK_MAX_LEVEL, black);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   function automatic sensor_word_type make_word(input command_type cmd,
                                                 input logic [SAMPLE_W-1:0] s0, s1, s2, s3, s4);
      sensor_word_type w;
      w.cmd    = cmd;
      w.smp[0] = s0;
      w.smp[1] = s1;
      w.smp[2] = s2;
      w.smp[3] = s3;
      w.smp[4] = s4;
      return w;
   endfunction

   // ---------------------------------------------------------------- result check

   initial begin
      result_type                   want;
      logic [CHANNELS-1:0][1:0]     got_lv;
      int c;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got_lv = {rsp_chan.level_4, rsp_chan.level_3, rsp_chan.level_2,
                      rsp_chan.level_1, rsp_chan.level_0};
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected: line_code %0d", rsp_chan.line_code);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               code_seen[rsp_chan.line_code] = 1'b1;
               if (rsp_chan.line_code !== want.line_code) begin
                  $error("line_code: expected %0d, got %0d", want.line_code, rsp_chan.line_code);
                  error_count++;
               end
               for (c = 0; c < CHANNELS; c++)
                  if (got_lv[c] !== want.level[c]) begin
                     $error("level_%0d: expected %0d, got %0d", c, want.level[c], got_lv[c]);
                     error_count++;
                  end
            end
         end
      end
   end

   // Result side back-pressure
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------- tests

   // Window prime on the first track word, then sample extremes and bit patterns
   task automatic test_window_prime();
      send_word(make_word(CMD_TRACK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
      send_word(make_word(CMD_TRACK, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000));
      send_word(make_word(CMD_TRACK, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
      send_word(make_word(CMD_TRACK, 12'h555, 12'hAAA, 12'h000, 12'hFFF, 12'h001));
   endtask

   // Calibrate skips zero samples, only lowers, and leaves the window alone
   task automatic test_calibrate_rules();
      send_word(make_word(CMD_CALIBRATE, 12'd0, 12'd1800, 12'hFFF, 12'd0, 12'd1950));
      send_word(make_word(CMD_TRACK, 12'd1700, 12'd1700, 12'd1700, 12'd1700, 12'd1700));
      send_word(make_word(CMD_CALIBRATE, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0));
      send_word(make_word(CMD_CALIBRATE, 12'd1900, 12'd1850, 12'd0, 12'd1990, 12'd1999));
      send_word(make_word(CMD_TRACK, 12'd1600, 12'd100, 12'd1850, 12'd520, 12'd4000));
   endtask

   // A write past the last register must change nothing; then all three registers are rewritten
   task automatic test_register_writes();
      wait_idle();
      write_csr(CSR_INDEX_UNUSED, 12'hFFF);
      csr_wr_en <= 1'b0;
      send_word(make_word(CMD_TRACK, 12'd1600, 12'd400, 12'd1800, 12'd510, 12'd3000));
      send_word(make_word(CMD_TRACK, 12'd450, 12'd1650, 12'd1750, 12'd1950, 12'd0));
      set_config(12'd300, 12'd50, 12'd800);
      send_word(make_word(CMD_TRACK, 12'd900, 12'd700, 12'd1500, 12'd1960, 12'd820));
      send_word(make_word(CMD_TRACK, 12'd810, 12'd790, 12'd1700, 12'd100, 12'd2500));
   endtask

   // Runs of one target pattern (or a random level set), plus calibrate and noise words
   task automatic run_traffic(input int n_words);
      sensor_word_type          target, w;
      level_type [CHANNELS-1:0] lv;
      int sent, run_len, pat, c, i, roll;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(99) < 75) begin
            pat = target_patterns[$urandom_range(N_TARGETS - 1)];
            for (c = CHANNELS - 1; c >= 0; c--) begin
               lv[c] = level_type'(pat % 10);
               pat   = pat / 10;
            end
         end else begin
            for (c = 0; c < CHANNELS; c++) lv[c] = level_type'($urandom_range(3));
         end
         target.cmd = CMD_TRACK;
         for (c = 0; c < CHANNELS; c++) target.smp[c] = sample_for_level(c, lv[c]);
         run_len = $urandom_range(70, 30);
         for (i = 0; i < run_len && sent < n_words; i++) begin
            roll = $urandom_range(99);
            w    = target;
            if (roll < 4) begin
               w.cmd = CMD_CALIBRATE;
               for (c = 0; c < CHANNELS; c++)
                  w.smp[c] = ($urandom_range(2) == 0) ? '0 :
                             SAMPLE_W'($urandom_range(SAMPLE_MAX, 1700));
            end else if (roll < 8) begin
               for (c = 0; c < CHANNELS; c++) w.smp[c] = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            end
            send_word(w);
            sent++;
         end
      end
   endtask

   // Register settings from reset values through both extremes to random ones
   task automatic test_random_traffic();
      set_config(OFFSET_RESET, BIAS_RESET, BLACK_RESET);
      run_traffic(130);
      set_config(12'd0, 12'd0, 12'd0);
      run_traffic(50);
      set_config(12'hFFF, 12'hFFF, 12'hFFF);
      run_traffic(50);
      set_config(SAMPLE_W'($urandom_range(800)), SAMPLE_W'($urandom_range(300)),
                 SAMPLE_W'($urandom_range(1200)));
      run_traffic(135);
      // no idling on either side for this stretch
      set_config(SAMPLE_W'($urandom_range(SAMPLE_MAX)), SAMPLE_W'($urandom_range(SAMPLE_MAX)),
                 SAMPLE_W'($urandom_range(SAMPLE_MAX)));
      steady_flow = 1'b1;
      run_traffic(135);
      wait_idle();
      steady_flow = 1'b0;
   endtask

   // Lowest nonzero calibrate sample; kept last since white minimums never rise again
   task automatic test_calibrate_floor();
      set_config(OFFSET_RESET, 12'd0, 12'd0);
      send_word(make_word(CMD_CALIBRATE, 12'd1, 12'hFFF, 12'd0, 12'd1, 12'd2));
      send_word(make_word(CMD_TRACK, 12'd0, 12'd1, 12'd2, 12'hFFF, 12'd1));
      send_word(make_word(CMD_CALIBRATE, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1));
      send_word(make_word(CMD_TRACK, 12'd1, 12'd0, 12'hFFF, 12'd1, 12'd0));
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      int c, n_codes;
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.command  = CMD_CALIBRATE;
      req_chan.sample_0 = '0;
      req_chan.sample_1 = '0;
      req_chan.sample_2 = '0;
      req_chan.sample_3 = '0;
      req_chan.sample_4 = '0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_WHITE_TO_RED_OFFSET;
      csr_wr_data     = '0;
      offset_reg      = OFFSET_RESET;
      bias_reg        = BIAS_RESET;
      black_reg       = BLACK_RESET;
      for (c = 0; c < CHANNELS; c++) begin
         white_low[c] = WHITE_RESET;
         run_sum[c]   = '0;
      end
      win_pos = 0;
      primed  = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_window_prime();
      test_calibrate_rules();
      test_register_writes();
      test_random_traffic();
      test_calibrate_floor();
      wait_idle();

      n_codes = 0;
      for (c = 0; c < 16; c++) if (code_seen[c]) n_codes++;
      $display("Sent %0d track and %0d calibrate words over %0d register settings",
               track_words, calibrate_words, n_settings);
      $display("Checked %0d result words; %0d distinct line codes came back, %0d errors",
               results_checked, n_codes, error_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
